[src/chd_pkg.sv]
// Shared types, constants and helpers for the chained hash dictionary core.
`default_nettype none
package chd_pkg;
  localparam int unsigned NODES = 16;
  localparam int unsigned BUCKETS = 16;
  localparam int unsigned PAYLOAD_BITS = 48;
  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CNT_W = $clog2(NODES + 1);
  localparam int unsigned KEY_W = 16;
  localparam int unsigned STEP_W = $clog2(NODES + 1);
  localparam int unsigned QDEPTH = 2;

  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_DELETED = 3'd1;
  localparam status_t ST_DUPLICATE = 3'd2;
  localparam status_t ST_FULL = 3'd3;
  localparam status_t ST_MISSING = 3'd4;

  typedef logic [LINK_W-1:0] link_t;
  localparam link_t LINK_NIL = {1'b1, {IDX_W{1'b0}}};

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic mode;
    logic [KEY_W-1:0] key;
    logic [PAYLOAD_BITS-1:0] data;
    logic [BKT_W-1:0] bucket;
  } req_t;

  // Bucket index: nibble sum reduced modulo the bucket count.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [5:0] sum;
    sum = 6'(key[3:0]) + 6'(key[7:4]) + 6'(key[11:8]) + 6'(key[15:12]);
    return BKT_W'(32'(sum) % BUCKETS);
  endfunction
endpackage
`default_nettype wire

[src/chained_hash_dict_node_pool_core.sv]
// Top level of the chained hash dictionary with a node pool and free list.
// An insert into a full pool is answered from the first walk step; any other
// item walks its bucket chain, one node read a step. Throughput:
// one item at a time in the back end; a two-entry queue keeps taking items
// meanwhile. Synchronous reset empties every chain, rebuilds the free list
// from the last node down and clears the record count.
`default_nettype none
module chained_hash_dict_node_pool_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [71:0] s_axis_tdata, // mode, key, payload, zero pad
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [15:0] m_axis_tdata // status, node_index, entry_count, zero pad
);
  import chd_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_req;
  logic [2:0] status;
  logic [IDX_W-1:0] node_index;
  logic [CNT_W-1:0] entry_count;

  chd_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .s_mode(s_axis_tdata[0]), .s_key(s_axis_tdata[16:1]),
    .s_data(s_axis_tdata[64:17]),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
  );

  chd_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
    .m_status(status), .m_node(node_index), .m_count(entry_count)
  );

  assign m_axis_tdata = {4'd0, entry_count, node_index, status};
endmodule
`default_nettype wire

[src/chd_front.sv]
// Front part: accepts requests, computes the bucket and queues them.
`default_nettype none
module chd_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic s_mode,
  input  wire logic [chd_pkg::KEY_W-1:0] s_key,
  input  wire logic [chd_pkg::PAYLOAD_BITS-1:0] s_data,
  output logic q_valid,
  input  wire logic q_pop,
  output chd_pkg::req_t q_req
);
  import chd_pkg::*;

  req_t entries [QDEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;

  assign s_tready = (fill != 2'(QDEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 2'd0);
  assign q_req = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{mode: s_mode, key: s_key, data: s_data, bucket: bucket_of(s_key)};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

[src/chd_back.sv]
// Back part: walks the bucket chain and applies the insert or delete.
`default_nettype none
module chd_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_pop,
  input  wire chd_pkg::req_t q_req,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [2:0] m_status,
  output logic [chd_pkg::IDX_W-1:0] m_node,
  output logic [chd_pkg::CNT_W-1:0] m_count
);
  import chd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DONE = 5'b00100,
    S_SEND = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state;
  req_t req;
  link_t bucket_head [BUCKETS];
  link_t node_link [NODES];
  logic [KEY_W-1:0] node_key [NODES];
  logic [PAYLOAD_BITS-1:0] node_data [NODES];
  link_t free_head;
  logic [CNT_W-1:0] record_total;
  link_t prev;
  link_t cur;
  logic [STEP_W-1:0] steps;
  logic [KEY_W-1:0] cur_key;
  logic cur_ok;
  logic walk_on;
  logic full;
  logic found;

  assign cur_ok = !cur[IDX_W];
  assign cur_key = node_key[cur[IDX_W-1:0]];
  assign full = (record_total >= CNT_W'(NODES)) || free_head[IDX_W];
  // Continue while the current node is before the target position.
  assign walk_on = cur_ok && (steps < STEP_W'(NODES)) &&
                   (req.mode ? (cur_key != req.key) : (cur_key < req.key));
  assign found = cur_ok && (cur_key == req.key);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign m_tvalid = (state == S_SEND);

  // Payload store, written on a successful insert.
  always_ff @(posedge clk) begin
    if (state == S_DONE && !req.mode && !found) begin
      node_key[free_head[IDX_W-1:0]] <= req.key;
      node_data[free_head[IDX_W-1:0]] <= req.data;
    end
  end

  // Sequencer and link state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < BUCKETS; i++) bucket_head[i] <= LINK_NIL;
      for (int i = 0; i < NODES; i++)
        node_link[i] <= (i == 0) ? LINK_NIL : LINK_W'(i - 1);
      free_head <= LINK_W'(NODES - 1);
      record_total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            req <= q_req;
            cur <= bucket_head[q_req.bucket];
            prev <= LINK_NIL;
            steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!req.mode && full) begin
            m_status <= ST_FULL;
            m_node <= '0;
            m_count <= record_total;
            state <= S_SEND;
          end else if (walk_on) begin
            prev <= cur;
            cur <= node_link[cur[IDX_W-1:0]];
            steps <= steps + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!req.mode) begin
            if (found) begin
              m_status <= ST_DUPLICATE;
              m_node <= '0;
              m_count <= record_total;
            end else begin
              free_head <= node_link[free_head[IDX_W-1:0]];
              node_link[free_head[IDX_W-1:0]] <= cur_ok ? cur : LINK_NIL;
              if (!prev[IDX_W]) node_link[prev[IDX_W-1:0]] <= free_head;
              else bucket_head[req.bucket] <= free_head;
              record_total <= record_total + 1'b1;
              m_count <= record_total + 1'b1;
              m_status <= ST_INSERTED;
              m_node <= free_head[IDX_W-1:0];
            end
          end else if (found) begin
            if (!prev[IDX_W]) node_link[prev[IDX_W-1:0]] <= node_link[cur[IDX_W-1:0]];
            else bucket_head[req.bucket] <= node_link[cur[IDX_W-1:0]];
            node_link[cur[IDX_W-1:0]] <= free_head;
            free_head <= cur;
            if (record_total != '0) begin
              record_total <= record_total - 1'b1;
              m_count <= record_total - 1'b1;
            end else begin
              m_count <= record_total;
            end
            m_status <= ST_DELETED;
            m_node <= cur[IDX_W-1:0];
          end else begin
            m_status <= ST_MISSING;
            m_node <= '0;
            m_count <= record_total;
          end
          state <= S_SEND;
        end
        S_SEND: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
